@@ rtl/core/tgarle_pkg.sv @@
// shared types, register indexes and helpers of the tga run-length decoder
`default_nettype none

package tgarle_pkg;

  localparam logic [1:0] REG_PIXEL_BYTES  = 2'd0;
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

  localparam int RunFlagBit = 7;

  typedef struct packed {
    logic [2:0]  pixel_bytes;
    logic [15:0] image_width;
    logic [15:0] image_height;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] pixel_value;
    logic [7:0]  repeat_count;
    logic        image_done;
    logic        overrun;
    logic        ignored;
  } result_t;

  function automatic logic [2:0] eff_pixel_bytes(input logic [2:0] raw);
    logic [2:0] eff;
    priority if (raw == 3'd0) begin
      eff = 3'd1;
    end else if (raw > 3'd4) begin
      eff = 3'd4;
    end else begin
      eff = raw;
    end
    return eff;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/tgarle_in_if.sv @@
// input byte channel
`default_nettype none

interface tgarle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       start_image;

  modport source (output valid, output in_byte, output start_image, input ready);
  modport sink   (input valid, input in_byte, input start_image, output ready);
endinterface

`default_nettype wire

@@ rtl/core/tgarle_out_if.sv @@
// decoded pixel result channel
`default_nettype none

interface tgarle_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_value;
  logic [7:0]  repeat_count;
  logic        image_done;
  logic        overrun;
  logic        ignored;

  modport source (output valid, output pixel_value, output repeat_count,
                  output image_done, output overrun, output ignored, input ready);
  modport sink   (input valid, input pixel_value, input repeat_count,
                  input image_done, input overrun, input ignored, output ready);
endinterface

`default_nettype wire

@@ rtl/core/tgarle_cfg_if.sv @@
// configuration write channel
`default_nettype none

interface tgarle_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/tga_rle_packet_decoder.sv @@
// top level of the tga run-length packet decoder
// Decodes one stream byte per cycle while out_bus is not stalled. A beat taken
// on in_bus lands in an input register and then goes through the header/pixel
// decode step into the result register, from which out_bus is driven; header
// bytes give no result beat. Throughput is one byte every cycle as long as
// out_bus is not stalled; a stall holds the result register and then the input
// register. The start byte forms image_width*image_height in the same cycle.
// cfg_bus is always ready; write it only while no byte is in flight. Width and
// height apply from the next start_image.
`default_nettype none

module tga_rle_packet_decoder (
  input  wire logic   clk,
  input  wire logic   rst_n,
  tgarle_in_if.sink   in_bus,
  tgarle_out_if.source out_bus,
  tgarle_cfg_if.sink  cfg_bus
);

  tgarle_pkg::cfg_t    cfg;
  tgarle_pkg::result_t res;
  tgarle_pkg::result_t out_r, out_nxt;

  logic       in_v_r, in_v_nxt;
  logic [7:0] byte_r;
  logic       start_r;
  logic       advance;
  logic       in_take;

  assign advance = in_v_r && (!out_r.valid || out_bus.ready);
  assign in_bus.ready = !in_v_r || advance;
  assign in_take = in_bus.valid && in_bus.ready;
  assign cfg_bus.ready = 1'b1;

  tgarle_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_bus.valid),
    .wr_index (cfg_bus.index),
    .wr_data  (cfg_bus.data),
    .cfg      (cfg)
  );

  tgarle_decode u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (advance),
    .in_byte     (byte_r),
    .start_image (start_r),
    .cfg         (cfg),
    .res         (res)
  );

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_take) begin
      in_v_nxt = 1'b1;
    end else if (advance) begin
      in_v_nxt = 1'b0;
    end
  end

  always_comb begin
    out_nxt = out_r;
    if (advance && res.valid) begin
      out_nxt = res;
    end else if (out_bus.ready) begin
      out_nxt.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      byte_r  <= in_bus.in_byte;
      start_r <= in_bus.start_image;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid <= 1'b0;
    end else begin
      out_r.valid <= out_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_r.pixel_value  <= out_nxt.pixel_value;
    out_r.repeat_count <= out_nxt.repeat_count;
    out_r.image_done   <= out_nxt.image_done;
    out_r.overrun      <= out_nxt.overrun;
    out_r.ignored      <= out_nxt.ignored;
  end

  assign out_bus.valid        = out_r.valid;
  assign out_bus.pixel_value  = out_r.pixel_value;
  assign out_bus.repeat_count = out_r.repeat_count;
  assign out_bus.image_done   = out_r.image_done;
  assign out_bus.overrun      = out_r.overrun;
  assign out_bus.ignored      = out_r.ignored;

  a_ignored_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_r.valid && out_r.ignored |->
      out_r.pixel_value == 32'd0 && out_r.repeat_count == 8'd0 &&
      !out_r.image_done && !out_r.overrun)
    else $error("ignored beat carries pixel data");

  a_overrun_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_r.valid && out_r.overrun |-> out_r.image_done)
    else $error("overrun without image completion");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_r.valid && !out_r.ignored |-> out_r.repeat_count != 8'd0)
    else $error("pixel beat with zero repeat count");

  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !advance |=> in_v_r && $stable(byte_r) && $stable(start_r))
    else $error("stalled input beat lost");

endmodule

`default_nettype wire

@@ rtl/core/tgarle_cfg_regs.sv @@
// configuration registers of the tga run-length decoder
`default_nettype none

module tgarle_cfg_regs (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [1:0]       wr_index,
  input  wire logic [15:0]      wr_data,
  output tgarle_pkg::cfg_t      cfg
);

  tgarle_pkg::cfg_t cfg_r;
  tgarle_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        tgarle_pkg::REG_PIXEL_BYTES:  cfg_nxt.pixel_bytes  = wr_data[2:0];
        tgarle_pkg::REG_IMAGE_WIDTH:  cfg_nxt.image_width  = wr_data;
        tgarle_pkg::REG_IMAGE_HEIGHT: cfg_nxt.image_height = wr_data;
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pixel_bytes  <= 3'd4;
      cfg_r.image_width  <= 16'd1;
      cfg_r.image_height <= 16'd1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

@@ rtl/core/tgarle_decode.sv @@
// packet and pixel state with the per-byte decode step
`default_nettype none

module tgarle_decode (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              fire,
  input  wire logic [7:0]        in_byte,
  input  wire logic              start_image,
  input  wire tgarle_pkg::cfg_t  cfg,
  output tgarle_pkg::result_t    res
);

  logic        phase_r, phase_nxt;
  logic        run_r, run_nxt;
  logic [7:0]  pkt_left_r, pkt_left_nxt;
  logic [1:0]  bip_r, bip_nxt;
  logic [31:0] accum_r, accum_nxt;
  logic [31:0] img_left_r, img_left_nxt;

  logic        phase_cur;
  logic        run_cur;
  logic [7:0]  pkt_cur;
  logic [1:0]  bip_cur;
  logic [31:0] accum_cur;
  logic        empty;
  logic [31:0] product;
  logic [31:0] acc_new;
  logic [2:0]  bip_inc;
  logic [2:0]  eff;
  logic        run_over;
  logic [7:0]  run_count;
  logic [7:0]  raw_pkt_new;
  logic        raw_done;

  assign product   = {16'd0, cfg.image_width} * {16'd0, cfg.image_height};
  assign phase_cur = start_image ? 1'b0 : phase_r;
  assign run_cur   = start_image ? 1'b0 : run_r;
  assign pkt_cur   = start_image ? 8'd0 : pkt_left_r;
  assign bip_cur   = start_image ? 2'd0 : bip_r;
  assign accum_cur = start_image ? 32'd0 : accum_r;
  assign empty     = start_image ? (cfg.image_width == 16'd0 || cfg.image_height == 16'd0)
                                 : (img_left_r == 32'd0);
  assign acc_new   = accum_cur | ({24'd0, in_byte} << {bip_cur, 3'b000});
  assign bip_inc   = {1'b0, bip_cur} + 3'd1;
  assign eff       = tgarle_pkg::eff_pixel_bytes(cfg.pixel_bytes);
  assign run_over  = {24'd0, pkt_cur} > img_left_r;
  assign run_count = run_over ? img_left_r[7:0] : pkt_cur;
  assign raw_pkt_new = pkt_cur - 8'd1;
  assign raw_done  = img_left_r == 32'd1;

  always_comb begin
    phase_nxt    = phase_cur;
    run_nxt      = run_cur;
    pkt_left_nxt = pkt_cur;
    bip_nxt      = bip_cur;
    accum_nxt    = accum_cur;
    img_left_nxt = start_image ? product : img_left_r;
    res          = '0;
    if (empty) begin
      res.valid   = 1'b1;
      res.ignored = 1'b1;
    end else if (!phase_cur) begin
      // header byte
      run_nxt      = in_byte[tgarle_pkg::RunFlagBit];
      pkt_left_nxt = {1'b0, in_byte[6:0]} + 8'd1;
      phase_nxt    = 1'b1;
      bip_nxt      = 2'd0;
      accum_nxt    = 32'd0;
    end else if (bip_inc < eff) begin
      bip_nxt   = bip_inc[1:0];
      accum_nxt = acc_new;
    end else begin
      res.valid       = 1'b1;
      res.pixel_value = acc_new;
      accum_nxt       = 32'd0;
      bip_nxt         = 2'd0;
      if (run_cur) begin
        res.repeat_count = run_count;
        res.overrun      = run_over;
        res.image_done   = !({24'd0, pkt_cur} < img_left_r);
        img_left_nxt     = img_left_r - {24'd0, run_count};
        pkt_left_nxt     = 8'd0;
        phase_nxt        = 1'b0;
      end else begin
        res.repeat_count = 8'd1;
        res.image_done   = raw_done;
        res.overrun      = raw_done && (raw_pkt_new != 8'd0);
        img_left_nxt     = img_left_r - 32'd1;
        pkt_left_nxt     = raw_pkt_new;
        if (raw_pkt_new == 8'd0 || raw_done) begin
          phase_nxt    = 1'b0;
          pkt_left_nxt = 8'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= 1'b0;
      run_r      <= 1'b0;
      pkt_left_r <= 8'd0;
      bip_r      <= 2'd0;
      accum_r    <= 32'd0;
      img_left_r <= 32'd0;
    end else if (fire) begin
      phase_r    <= phase_nxt;
      run_r      <= run_nxt;
      pkt_left_r <= pkt_left_nxt;
      bip_r      <= bip_nxt;
      accum_r    <= accum_nxt;
      img_left_r <= img_left_nxt;
    end
  end

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// self-checking testbench of the tga run-length packet decoder
`timescale 1ns / 100ps

module testbench;

  typedef struct packed {
    logic [31:0] value;
    logic [7:0]  count;
    logic        done;
    logic        over;
    logic        ign;
  } pixel_beat_t;

  typedef enum logic [1:0] {FROM_MODEL, GIVEN_NONE, GIVEN_BEAT, REG_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [7:0]  data_byte;
    logic        start;
    logic [1:0]  reg_idx;
    logic [15:0] reg_val;
    pixel_beat_t beat;
  } row_t;

  localparam int DirectedRows = 38;
  localparam int RandomBytes = 650;
  localparam pixel_beat_t IGNORED_BEAT = '{32'h0, 8'd0, 1'b0, 1'b0, 1'b1};

  logic clk;
  logic rst_n;

  tgarle_in_if  in_ch();
  tgarle_out_if out_ch();
  tgarle_cfg_if cfg_ch();

  tga_rle_packet_decoder dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_ch),
    .out_bus (out_ch),
    .cfg_bus (cfg_ch)
  );

  // decoder shadow: registers and packet state
  logic [2:0]  pix_size_reg = 3'd4;
  logic [15:0] width_reg = 16'd1;
  logic [15:0] height_reg = 16'd1;
  logic        in_packet = 1'b0;
  logic        run_mode = 1'b0;
  logic [7:0]  packet_left = 8'd0;
  logic [2:0]  bytes_held = 3'd0;
  logic [31:0] pixel_acc = 32'd0;
  logic [31:0] pixels_left = 32'd0;

  pixel_beat_t pending_pixels[$];
  row_kind_t   item_kind;
  pixel_beat_t item_given;
  row_t        plan [DirectedRows];
  int          mismatches = 0;
  int          bytes_sent = 0;
  int          stall_left = 0;
  bit          quiet = 1'b0;

  always #5 clk = ~clk;

  function automatic logic [2:0] pixel_size(input logic [2:0] raw);
    if (raw == 3'd0) return 3'd1;
    return (raw > 3'd4) ? 3'd4 : raw;
  endfunction

  function automatic bit decode_byte(input logic [7:0] b, input logic s,
                                     output pixel_beat_t r);
    logic [31:0] cnt;
    r = '0;
    if (s) begin
      pixels_left = {16'd0, width_reg} * {16'd0, height_reg};
      in_packet = 1'b0;
      run_mode = 1'b0;
      packet_left = 8'd0;
      bytes_held = 3'd0;
      pixel_acc = 32'd0;
    end
    if (pixels_left == 32'd0) begin
      r = IGNORED_BEAT;
      return 1'b1;
    end
    if (!in_packet) begin
      run_mode = b[tgarle_pkg::RunFlagBit];
      packet_left = {1'b0, b[6:0]} + 8'd1;
      in_packet = 1'b1;
      bytes_held = 3'd0;
      pixel_acc = 32'd0;
      return 1'b0;
    end
    pixel_acc = pixel_acc | (32'(b) << (8 * bytes_held[1:0]));
    bytes_held = bytes_held + 3'd1;
    if (bytes_held < pixel_size(pix_size_reg)) return 1'b0;
    r.value = pixel_acc;
    pixel_acc = 32'd0;
    bytes_held = 3'd0;
    if (run_mode) begin
      if ({24'd0, packet_left} > pixels_left) begin
        cnt = pixels_left;
        r.over = 1'b1;
      end else begin
        cnt = {24'd0, packet_left};
      end
      pixels_left = pixels_left - cnt;
      packet_left = 8'd0;
    end else begin
      cnt = 32'd1;
      pixels_left = pixels_left - 32'd1;
      if (packet_left != 8'd0) packet_left = packet_left - 8'd1;
      r.over = (pixels_left == 32'd0) && (packet_left != 8'd0);
    end
    r.count = cnt[7:0];
    r.done = (pixels_left == 32'd0);
    if (packet_left == 8'd0 || r.done) begin
      in_packet = 1'b0;
      packet_left = 8'd0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 99) < 20) begin
      stall_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    pixel_beat_t predicted;
    pixel_beat_t want;
    pixel_beat_t seen;
    bit          made;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          tgarle_pkg::REG_PIXEL_BYTES:  pix_size_reg = cfg_ch.data[2:0];
          tgarle_pkg::REG_IMAGE_WIDTH:  width_reg = cfg_ch.data;
          tgarle_pkg::REG_IMAGE_HEIGHT: height_reg = cfg_ch.data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        made = decode_byte(in_ch.in_byte, in_ch.start_image, predicted);
        case (item_kind)
          GIVEN_BEAT: pending_pixels.push_back(item_given);
          GIVEN_NONE: ;
          default: if (made) pending_pixels.push_back(predicted);
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        seen = {out_ch.pixel_value, out_ch.repeat_count, out_ch.image_done,
                out_ch.overrun, out_ch.ignored};
        if (pending_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected beat: value=%h count=%0d done=%b over=%b ign=%b",
                     seen.value, seen.count, seen.done, seen.over, seen.ign);
        end else begin
          want = pending_pixels.pop_front();
          if (seen !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp value=%h count=%0d done=%b over=%b ign=%b",
                       want.value, want.count, want.done, want.over, want.ign,
                       ", got value=%h count=%0d done=%b over=%b ign=%b",
                       seen.value, seen.count, seen.done, seen.over, seen.ign);
          end
        end
      end
    end
  end

  task automatic send(input logic [7:0] b, input logic s, input row_kind_t kind,
                      input pixel_beat_t given);
    int gap;
    int r;
    gap = 0;
    if (!quiet) begin
      r = $urandom_range(0, 99);
      gap = (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(4, 20);
    end
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.start_image <= s;
    item_kind <= kind;
    item_given <= given;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  task automatic feed(input int b, input int s);
    send(8'(b), 1'(s), FROM_MODEL, '0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  initial begin
    #10ms;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int          base;
    int          sz;
    int          len;
    int          run;
    int          pkts;
    int          r;
    longint      togo;
    bit          first;
    bit          broken;
    bit          cfg_open;
    logic [2:0]  pb;
    logic [15:0] w;
    logic [15:0] h;

    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.in_byte = 8'd0;
    in_ch.start_image = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = tgarle_pkg::REG_PIXEL_BYTES;
    cfg_ch.data = 16'd0;
    out_ch.ready = 1'b0;
    item_kind = FROM_MODEL;
    item_given = '0;
    cfg_open = 1'b0;

    plan = '{
      '{GIVEN_BEAT, 8'h5A, 1'b0, tgarle_pkg::REG_PIXEL_BYTES, 16'h0, IGNORED_BEAT},
      '{GIVEN_NONE, 8'h80, 1'b1, tgarle_pkg::REG_PIXEL_BYTES, 16'h0, '0},
      '{GIVEN_NONE, 8'h11, 1'b0, tgarle_pkg::REG_PIXEL_BYTES, 16'h0, '0},
      '{GIVEN_NONE, 8'h22, 1'b0, tgarle_pkg::REG_PIXEL_BYTES, 16'h0, '0},
      '{GIVEN_NONE, 8'h33, 1'b0, tgarle_pkg::REG_PIXEL_BYTES, 16'h0, '0},
      '{GIVEN_BEAT, 8'h44, 1'b0, tgarle_pkg::REG_PIXEL_BYTES, 16'h0,
        '{32'h44332211, 8'd1, 1'b1, 1'b0, 1'b0}},
      '{REG_WRITE, 8'h00, 1'b0, tgarle_pkg::REG_PIXEL_BYTES, 16'd1, '0},
      '{REG_WRITE, 8'h00, 1'b0, tgarle_pkg::REG_IMAGE_WIDTH, 16'd3, '0},
      '{REG_WRITE, 8'h00, 1'b0, tgarle_pkg::REG_IMAGE_HEIGHT, 16'd1, '0},
      // run of 128 clamped to 3 pixels
      '{GIVEN_NONE, 8'hFF, 1'b1, tgarle_pkg::REG_PIXEL_BYTES, 16'h0, '0},
      '{GIVEN_BEAT, 8'hAB, 1'b0, tgarle_pkg::REG_PIXEL_BYTES, 16'h0,
        '{32'h000000AB, 8'd3, 1'b1, 1'b1, 1'b0}},
      '{REG_WRITE, 8'h00, 1'b0, tgarle_pkg::REG_PIXEL_BYTES, 16'd2, '0},
      '{REG_WRITE, 8'h00, 1'b0, tgarle_pkg::REG_IMAGE_WIDTH, 16'd2, '0},
      '{REG_WRITE, 8'h00, 1'b0, tgarle_pkg::REG_IMAGE_HEIGHT, 16'd2, '0},
      '{GIVEN_NONE, 8'h7F, 1'b1, tgarle_pkg::REG_PIXEL_BYTES, 16'h0, '0},
      '{FROM_MODEL, 8'h00, 1'b0, tgarle_pkg::REG_PIXEL_BYTES, 16'h0, '0},
      '{FROM_MODEL, 8'hFF, 1'b0, tgarle_pkg::REG_PIXEL_BYTES, 16'h0, '0},
      '{FROM_MODEL, 8'h10, 1'b0, tgarle_pkg::REG_PIXEL_BYTES, 16'h0, '0},
      // size shrinks mid-pixel, width change waits for next start
      '{REG_WRITE, 8'h00, 1'b0, tgarle_pkg::REG_PIXEL_BYTES, 16'd1, '0},
      '{REG_WRITE, 8'h00, 1'b0, tgarle_pkg::REG_IMAGE_WIDTH, 16'd0, '0},
      '{FROM_MODEL, 8'h20, 1'b0, tgarle_pkg::REG_PIXEL_BYTES, 16'h0, '0},
      '{FROM_MODEL, 8'h30, 1'b0, tgarle_pkg::REG_PIXEL_BYTES, 16'h0, '0},
      '{FROM_MODEL, 8'h40, 1'b0, tgarle_pkg::REG_PIXEL_BYTES, 16'h0, '0},
      '{GIVEN_BEAT, 8'h50, 1'b0, tgarle_pkg::REG_PIXEL_BYTES, 16'h0, IGNORED_BEAT},
      '{GIVEN_BEAT, 8'h00, 1'b1, tgarle_pkg::REG_PIXEL_BYTES, 16'h0, IGNORED_BEAT},
      '{REG_WRITE, 8'h00, 1'b0, tgarle_pkg::REG_PIXEL_BYTES, 16'd0, '0},
      '{REG_WRITE, 8'h00, 1'b0, tgarle_pkg::REG_IMAGE_WIDTH, 16'hFFFF, '0},
      '{REG_WRITE, 8'h00, 1'b0, tgarle_pkg::REG_IMAGE_HEIGHT, 16'hFFFF, '0},
      '{GIVEN_NONE, 8'h81, 1'b1, tgarle_pkg::REG_PIXEL_BYTES, 16'h0, '0},
      '{FROM_MODEL, 8'hC3, 1'b0, tgarle_pkg::REG_PIXEL_BYTES, 16'h0, '0},
      '{GIVEN_NONE, 8'h02, 1'b0, tgarle_pkg::REG_PIXEL_BYTES, 16'h0, '0},
      '{FROM_MODEL, 8'h55, 1'b0, tgarle_pkg::REG_PIXEL_BYTES, 16'h0, '0},
      // restart inside a raw packet
      '{REG_WRITE, 8'h00, 1'b0, tgarle_pkg::REG_PIXEL_BYTES, 16'd7, '0},
      '{GIVEN_NONE, 8'h85, 1'b1, tgarle_pkg::REG_PIXEL_BYTES, 16'h0, '0},
      '{FROM_MODEL, 8'hFF, 1'b0, tgarle_pkg::REG_PIXEL_BYTES, 16'h0, '0},
      '{FROM_MODEL, 8'hFF, 1'b0, tgarle_pkg::REG_PIXEL_BYTES, 16'h0, '0},
      '{FROM_MODEL, 8'hFF, 1'b0, tgarle_pkg::REG_PIXEL_BYTES, 16'h0, '0},
      '{FROM_MODEL, 8'hFF, 1'b0, tgarle_pkg::REG_PIXEL_BYTES, 16'h0, '0}
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == REG_WRITE) begin
        if (!cfg_open) settle();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) begin
          cfg_ch.valid <= 1'b0;
          cfg_open = 1'b0;
        end
        send(plan[i].data_byte, plan[i].start, plan[i].kind, plan[i].beat);
      end
    end

    base = bytes_sent;
    while (bytes_sent - base < RandomBytes) begin
      settle();
      quiet = ($urandom_range(0, 3) == 0);
      pb = ($urandom_range(0, 2) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 4));
      r = $urandom_range(0, 19);
      case (r)
        0: begin
          w = 16'd0;
          h = 16'($urandom_range(1, 3));
        end
        1: begin
          w = 16'($urandom_range(1, 3));
          h = 16'd0;
        end
        2: begin
          w = 16'hFFFF;
          h = 16'd1;
        end
        3: begin
          w = 16'd1;
          h = 16'hFFFF;
        end
        4: begin
          w = 16'hFFFF;
          h = 16'hFFFF;
        end
        default: begin
          w = 16'($urandom_range(1, 6));
          h = 16'($urandom_range(1, 4));
        end
      endcase
      write_reg(tgarle_pkg::REG_PIXEL_BYTES, {13'd0, pb});
      write_reg(tgarle_pkg::REG_IMAGE_WIDTH, w);
      write_reg(tgarle_pkg::REG_IMAGE_HEIGHT, h);
      cfg_ch.valid <= 1'b0;
      sz = int'(pixel_size(pb));

      repeat ($urandom_range(1, 3)) begin
        togo = longint'(w) * longint'(h);
        if (togo == 0) begin
          feed($urandom_range(0, 255), 1);
          repeat ($urandom_range(0, 2)) feed($urandom_range(0, 255), 0);
        end else begin
          pkts = 0;
          first = 1'b1;
          broken = 1'b0;
          while (togo > 0 && pkts < 8 && !broken) begin
            run = $urandom_range(0, 1);
            if (run != 0) begin
              r = $urandom_range(0, 9);
              len = (r < 5) ? $urandom_range(0, 7) : (r < 8) ? $urandom_range(0, 127) : 127;
            end else begin
              len = ($urandom_range(0, 99) < 3) ? $urandom_range(0, 127) : $urandom_range(0, 7);
            end
            feed((run << tgarle_pkg::RunFlagBit) | len, int'(first));
            first = 1'b0;
            if ($urandom_range(0, 19) == 0) begin
              // cut the packet short, the next image restarts
              repeat ($urandom_range(0, sz)) feed($urandom_range(0, 255), 0);
              broken = 1'b1;
            end else begin
              repeat ((run != 0) ? sz : sz * (len + 1)) feed($urandom_range(0, 255), 0);
              togo = togo - (len + 1);
              if ($urandom_range(0, 29) == 0)
                feed($urandom_range(0, 255), $urandom_range(0, 1));
            end
            pkts++;
          end
          if (togo <= 0) repeat ($urandom_range(0, 2)) feed($urandom_range(0, 255), 0);
        end
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
